[rtl/core/kzis_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and small helpers of the iterated KZ smoother.
// Depends on nothing; the top level refers to it by scoped names.
package kzis_pkg;

  localparam int HISTORY_DEPTH = 17;
  localparam int MID_TAP       = HISTORY_DEPTH / 2;
  localparam int WINDOW_LENGTH = 5;
  localparam int HALF_STEP     = (WINDOW_LENGTH - 1) / 2;
  localparam int ROW_COUNT     = 4;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int WEIGHT_W      = 7;
  localparam int REM_W         = 10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       pass_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_WB    = 5'b10000
  } state_e;

  // Binomial-like weight rows, one per pass; pass p sums to 5^p.
  localparam logic [WEIGHT_W-1:0] WEIGHTS [ROW_COUNT][HISTORY_DEPTH] = '{
    '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd0, 7'd0, 7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd4, 7'd3,
      7'd2, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd0, 7'd1, 7'd3, 7'd6, 7'd10, 7'd15, 7'd18, 7'd19, 7'd18, 7'd15,
      7'd10, 7'd6, 7'd3, 7'd1, 7'd0, 7'd0},
    '{7'd1, 7'd4, 7'd10, 7'd20, 7'd35, 7'd52, 7'd68, 7'd80, 7'd85, 7'd80, 7'd68,
      7'd52, 7'd35, 7'd20, 7'd10, 7'd4, 7'd1}
  };

  // 5^p for each pass.
  localparam logic [REM_W-1:0] DIVISORS [ROW_COUNT] = '{
    10'd5, 10'd25, 10'd125, 10'd625
  };

  // Map a logical delay-line index onto a physical slot of the ring.
  function automatic idx_t phys_addr(input idx_t base, input idx_t ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (IDX_W + 1)'(HISTORY_DEPTH)) begin
      sum = sum - (IDX_W + 1)'(HISTORY_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic idx_t tap_first(input pass_t pass);
    return IDX_W'(MID_TAP - HALF_STEP * (int'(pass) + 1));
  endfunction

  function automatic idx_t tap_last(input pass_t pass);
    return IDX_W'(MID_TAP + HALF_STEP * (int'(pass) + 1));
  endfunction

endpackage

[rtl/core/kzis_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module kzis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/kz_iterated_smoother_top.sv]
`timescale 1ns / 1ps
// Top level of the iterated Kolmogorov-Zurbenko smoother (window 5).
// Depends on kzis_pkg and kzis_ram.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o    | sample_i   [SAMPLE_WIDTH]
//   out     | output    | out_valid_o / out_ready_i  | smoothed_o [SAMPLE_WIDTH]
//
// Each pass of a transaction runs through the one shared multiply-accumulate
// (one tap per cycle through the single RAM read port) and the radix-16
// divider (one digit per cycle), which forms NDIG = ceil((SAMPLE_WIDTH + 9) / 4)
// quotient digits.
// Reset clears the control state and the per-entry valid bits at once; an
// entry not yet written reads as zero, so no clearing sweep is needed.
// A result waits in the output register; a new sample is taken meanwhile, and
// the block holds in write-back only if the previous result is still untaken.
module kz_iterated_smoother_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int PASSES       = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SAMPLE_WIDTH-1:0] smoothed_o
);

  // Accumulator holds up to 2^(SW-1) * 625; magnitude fits SW+9 bits.
  localparam int ACC_W  = SAMPLE_WIDTH + 10;
  localparam int PROD_W = SAMPLE_WIDTH + kzis_pkg::WEIGHT_W + 1;
  localparam int MAG_W  = SAMPLE_WIDTH + 9;
  localparam int NDIG   = (MAG_W + 3) / 4;
  localparam int DIV_W  = NDIG * 4;
  localparam int DIG_W  = $clog2(NDIG);
  localparam int T_W    = kzis_pkg::REM_W + 4;

  // Control state
  kzis_pkg::state_e                     state_q, state_d;
  kzis_pkg::idx_t                       ptr_q, ptr_d;
  kzis_pkg::idx_t                       idx_q, idx_d;
  kzis_pkg::pass_t                      pass_q, pass_d;
  logic [kzis_pkg::HISTORY_DEPTH-1:0]   vld_q, vld_d;
  logic [DIG_W-1:0]                     dig_q, dig_d;
  logic                                 rd_pend_q, rd_live_q, prod_vld_q;
  logic                                 out_valid_q, out_valid_d;

  // Datapath
  logic [kzis_pkg::WEIGHT_W-1:0]        w1_q, w_d;
  logic signed [PROD_W-1:0]             prod_q, prod_d;
  logic signed [ACC_W-1:0]              acc_q, acc_d;
  logic                                 neg_q, neg_d;
  logic [DIV_W-1:0]                     div_q, div_d;
  logic [kzis_pkg::REM_W-1:0]           rem_q, rem_d;
  logic [SAMPLE_WIDTH-1:0]              out_q, out_d;

  // RAM port
  logic                                 mem_we, mem_re;
  kzis_pkg::idx_t                       mem_waddr, mem_raddr;
  logic [SAMPLE_WIDTH-1:0]              mem_wdata, mem_rdata;

  logic                                 rd_issue;
  logic                                 pass_last;
  logic                                 out_free;
  logic [SAMPLE_WIDTH-1:0]              tap;
  logic [ACC_W-1:0]                     acc_abs;
  logic [kzis_pkg::REM_W-1:0]           dvsr;
  logic [T_W-1:0]                       dig_t;
  logic [3:0]                           dig_q_val;
  logic [T_W-1:0]                       dig_r;
  logic [DIV_W-1:0]                     res_full;
  kzis_pkg::idx_t                       mid_addr;

  kzis_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (kzis_pkg::HISTORY_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o  = (state_q == kzis_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign smoothed_o  = out_q;

  assign pass_last = (pass_q == 2'(PASSES - 1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign mid_addr  = kzis_pkg::phys_addr(ptr_q, kzis_pkg::IDX_W'(kzis_pkg::MID_TAP));

  // Entries never written read as zero, matching the cleared delay line.
  assign tap    = rd_live_q ? mem_rdata : '0;
  assign prod_d = $signed(tap) * $signed({1'b0, w1_q});

  assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  // Radix-16 long division of the magnitude by 5^p: one digit per cycle.
  assign dvsr  = kzis_pkg::DIVISORS[pass_q];
  assign dig_t = {rem_q, div_q[DIV_W-1 -: 4]};

  always_comb begin
    dig_q_val = '0;
    for (int k = 1; k < 16; k++) begin
      if (dig_t >= T_W'(k) * T_W'(dvsr)) begin
        dig_q_val = dig_q_val + 4'd1;
      end
    end
    dig_r = dig_t - T_W'(dig_q_val) * T_W'(dvsr);
  end

  // Quotient is a magnitude; restore the sign to truncate toward zero.
  assign res_full = neg_q ? DIV_W'(-div_q) : div_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    pass_d      = pass_q;
    vld_d       = vld_q;
    dig_d       = dig_q;
    acc_d       = prod_vld_q ? acc_q + ACC_W'(prod_q) : acc_q;
    neg_d       = neg_q;
    div_d       = div_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = sample_i;
    mem_re      = 1'b0;
    mem_raddr   = kzis_pkg::phys_addr(ptr_q, idx_q);
    rd_issue    = 1'b0;
    w_d         = kzis_pkg::WEIGHTS[pass_q][idx_q];

    case (state_q)
      kzis_pkg::ST_IDLE: begin
        // Overwrite the oldest slot with the new sample and rotate the ring.
        if (in_valid_i) begin
          mem_we       = 1'b1;
          vld_d[ptr_q] = 1'b1;
          ptr_d        = (ptr_q == kzis_pkg::IDX_W'(kzis_pkg::HISTORY_DEPTH - 1)) ?
                         '0 : ptr_q + 1'b1;
          pass_d       = '0;
          idx_d        = kzis_pkg::tap_first('0);
          acc_d        = '0;
          state_d      = kzis_pkg::ST_RUN;
        end
      end
      kzis_pkg::ST_RUN: begin
        // Issue one tap read per cycle across the window of this pass.
        mem_re   = 1'b1;
        rd_issue = 1'b1;
        if (idx_q == kzis_pkg::tap_last(pass_q)) begin
          state_d = kzis_pkg::ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      kzis_pkg::ST_DRAIN: begin
        // Wait for the read and multiply stages to empty into the accumulator.
        if (!rd_pend_q && !prod_vld_q) begin
          neg_d   = acc_q[ACC_W-1];
          div_d   = DIV_W'(acc_abs[MAG_W-1:0]);
          rem_d   = '0;
          dig_d   = '0;
          state_d = kzis_pkg::ST_DIV;
        end
      end
      kzis_pkg::ST_DIV: begin
        div_d = {div_q[DIV_W-5:0], dig_q_val};
        rem_d = dig_r[kzis_pkg::REM_W-1:0];
        dig_d = dig_q + 1'b1;
        if (dig_q == DIG_W'(NDIG - 1)) begin
          state_d = kzis_pkg::ST_WB;
        end
      end
      kzis_pkg::ST_WB: begin
        // Write the pass result back to the middle entry; the next pass starts its
        // reads in the cycle after the write, so the read sees it without forwarding.
        // Mark the entry live so later reads return the written value.
        mem_waddr = mid_addr;
        mem_wdata = res_full[SAMPLE_WIDTH-1:0];
        if (pass_last) begin
          if (out_free) begin
            mem_we          = 1'b1;
            vld_d[mid_addr] = 1'b1;
            out_d           = res_full[SAMPLE_WIDTH-1:0];
            out_valid_d     = 1'b1;
            state_d         = kzis_pkg::ST_IDLE;
          end
        end else begin
          mem_we          = 1'b1;
          vld_d[mid_addr] = 1'b1;
          pass_d          = pass_q + 2'd1;
          idx_d           = kzis_pkg::tap_first(pass_q + 2'd1);
          acc_d           = '0;
          state_d         = kzis_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = kzis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kzis_pkg::ST_IDLE;
      ptr_q       <= '0;
      idx_q       <= '0;
      pass_q      <= '0;
      vld_q       <= '0;
      dig_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_live_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      idx_q       <= idx_d;
      pass_q      <= pass_d;
      vld_q       <= vld_d;
      dig_q       <= dig_d;
      rd_pend_q   <= rd_issue;
      rd_live_q   <= vld_q[mem_raddr];
      prod_vld_q  <= rd_pend_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      w1_q <= w_d;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  // The multiply-accumulate pipeline is empty whenever a new sample can enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!rd_pend_q && !prod_vld_q))
    else $error("MAC pipeline busy while accepting a sample");

  // Writes and tap reads never share a cycle, so no same-entry hazard exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("delay-line write overlaps a tap read");

  // Ring pointer stays within the delay line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= kzis_pkg::IDX_W'(kzis_pkg::HISTORY_DEPTH - 1))
    else $error("ring pointer out of range");

  // A finished last pass with a free output slot shows its result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kzis_pkg::ST_WB && pass_last && out_free) |=> out_valid_o)
    else $error("result lost at write-back");

endmodule

[test/kz_smoother_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for kz_iterated_smoother_top: predicts every smoothed output
// from the accepted samples and compares it with what the block delivers.
// Stand-alone; needs only the sample width of the smoother and assumes three passes.
module kz_smoother_checker #(
  parameter int SAMPLE_W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [SAMPLE_W-1:0] smoothed_i,
  output int                  mismatch_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int DEPTH    = 17;
  localparam int MID      = DEPTH / 2;
  localparam int N_PASS   = 3;
  localparam int WIN      = 5;
  localparam int MAX_SHOW = 10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Pass p weights sum to 5^p; taps outside the pass span are zero.
  localparam int TAP_WEIGHT [N_PASS][DEPTH] = '{
    '{0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 1, 2, 3, 4, 5, 4, 3, 2, 1, 0, 0, 0, 0},
    '{0, 0, 1, 3, 6, 10, 15, 18, 19, 18, 15, 10, 6, 3, 1, 0, 0}
  };

  sample_t history [DEPTH];
  sample_t expected_smoothed [$];
  sample_t want;
  int      mismatches;
  int      checked;

  // Shift one sample into the history, run the three in-place passes and
  // return the new middle entry.
  function automatic sample_t smooth_next(input sample_t fresh);
    longint acc;
    longint divisor;
    for (int i = 0; i < DEPTH - 1; i++) begin
      history[i] = history[i + 1];
    end
    history[DEPTH - 1] = fresh;
    divisor = 1;
    for (int p = 0; p < N_PASS; p++) begin
      acc = 0;
      for (int i = 0; i < DEPTH; i++) begin
        acc += longint'(history[i]) * TAP_WEIGHT[p][i];
      end
      divisor *= WIN;
      // Signed division truncates toward zero.
      history[MID] = sample_t'(acc / divisor);
    end
    return history[MID];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        history[i] = '0;
      end
      expected_smoothed.delete();
      mismatches = 0;
      checked    = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (expected_smoothed.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOW) begin
            $display("%t checker: unexpected smoothed output %0d", $realtime,
                     $signed(smoothed_i));
          end
        end else begin
          want = expected_smoothed.pop_front();
          if (smoothed_i !== want) begin
            mismatches++;
            if (mismatches <= MAX_SHOW) begin
              $display("%t checker: smoothed mismatch, expected %0d, got %0d",
                       $realtime, want, $signed(smoothed_i));
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_smoothed.push_back(smooth_next(sample_t'(sample_i)));
      end
      // Publish with nonblocking updates so readers see a stable value.
      mismatch_count_o <= mismatches;
      pending_o        <= expected_smoothed.size();
      checked_o        <= checked;
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for kz_iterated_smoother_top: clock, reset, sample stimulus,
// output back-pressure, watchdog and verdict. Depends on kz_smoother_checker.
module tb_top;

  localparam int SAMPLE_W   = 16;
  localparam int N_RANDOM   = 1350;
  localparam int N_PHASES   = 6;
  localparam int DOG_LIMIT  = 4000;
  localparam int SETTLE_CYC = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] smoothed;

  int mismatch_count;
  int pending;
  int checked;
  int sent;
  int idle_cycles = 0;

  // Idle profile of the current phase; read by the sender and the receiver.
  bit src_idles;
  bit sink_idles;

  logic [SAMPLE_W-1:0] last_value;

  // Directed samples: full-scale impulse, small negatives that make the
  // weighted sums truncate toward zero, a run of nine of the most negative
  // value, then full-scale alternation.
  localparam logic [SAMPLE_W-1:0] DIRECTED [25] = '{
    16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
    16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFD, 16'h0007,
    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
    16'h8000, 16'h8000, 16'h8000, 16'h8000,
    16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h0000
  };

  always #4 clk_i = ~clk_i;

  kz_iterated_smoother_top #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .PASSES      (3)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .sample_i   (sample),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .smoothed_o (smoothed)
  );

  kz_smoother_checker #(
    .SAMPLE_W(SAMPLE_W)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .sample_i        (sample),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .smoothed_i      (smoothed),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // Gap length: one of three ranges, picked with falling odds as the ranges lengthen.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return $urandom_range(1, 3);
    end else if (r < 90) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(13, 250);
  endfunction

  // Send one sample. Call at a rising edge; return at the edge that accepts
  // the transaction, with valid still high so the next call can chain on.
  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = 0;
    if (src_idles && $urandom_range(0, 2) == 0) begin
      gap = idle_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk_i); while (!in_ready);
    sent++;
    last_value = value;
  endtask

  // Pick the next random sample for the given signal shape.
  function automatic logic [SAMPLE_W-1:0] shaped_value(input int shape);
    case (shape)
      0: return SAMPLE_W'($urandom_range(0, 65535));
      // Near zero, so truncation of negative sums matters.
      1: return SAMPLE_W'($urandom_range(0, 16) - 8);
      2: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'hFFFF;
          3:       return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      // Mostly flat signal with rare steps; lets the history saturate.
      3: begin
        if ($urandom_range(0, 9) == 0) begin
          return SAMPLE_W'($urandom_range(0, 65535));
        end
        return last_value;
      end
      // Random walk that wraps around the full range.
      default: return last_value + SAMPLE_W'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  // Hold off until the checker has every predicted output back.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Receiver: keep ready high, or stall for random stretches when allowed.
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_idles && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles without any transaction on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= DOG_LIMIT) begin
        $display("%t tb_top: no transaction for %0d cycles", $realtime, DOG_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int shape;
    int shape_left;
    sent        = 0;
    last_value  = '0;
    src_idles   = 1'b0;
    sink_idles  = 1'b1;
    shape       = 0;
    shape_left  = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: back-to-back samples, receiver stalling at random.
    foreach (DIRECTED[i]) begin
      push_sample(DIRECTED[i]);
    end
    drain_outputs();

    // Random part: the idle profile is set per phase; phase 0 and the last
    // run with no idling at all. Drain fully once in the middle.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      src_idles  = (ph == 1) || (ph == 3) || (ph == 4);
      sink_idles = (ph >= 2) && (ph != N_PHASES - 1);
      for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
        if (shape_left == 0) begin
          shape      = $urandom_range(0, 4);
          shape_left = $urandom_range(10, 60);
        end
        shape_left--;
        push_sample(shaped_value(shape));
      end
      if (ph == 2) begin
        drain_outputs();
      end
    end

    // Drop valid, wait for every outstanding result, then let the block settle.
    drain_outputs();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("tb_top: %0d samples sent, %0d smoothed outputs compared, %0d mismatches",
             sent, checked, mismatch_count);
    $display("tb_top: covered impulse, full-scale and near-zero inputs, flat, walk %s",
             "and random signals under source gaps and sink stalls");
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
